[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEPK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SEPK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/sepk_pkg.sv]
// Shared types, constants and size-code functions of the skip record packer.
// No dependencies; every module file refers to it by scoped names.
package sepk_pkg;

    localparam int SegCnt     = 6;
    localparam int SlotW      = $clog2(SegCnt);
    localparam int QueueDepth = 2;
    localparam int CfgIdxW    = 2;

    localparam logic [CfgIdxW-1:0] RegHasPositions = 2'd0;
    localparam logic [CfgIdxW-1:0] RegHasOffsets   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMsbFirst     = 2'd2;

    typedef enum logic [1:0] {
        ACT_SKIP    = 2'd0,
        ACT_INLINE  = 2'd1,
        ACT_SCORE   = 2'd2,
        ACT_POSMETA = 2'd3
    } action_t;

    typedef struct packed {
        logic has_positions;
        logic has_offsets;
        logic msb_first;
    } cfg_t;

    // One record: up to SegCnt segments, each a value and a byte count (0 = absent).
    typedef struct packed {
        logic [SegCnt-1:0][63:0] val;
        logic [SegCnt-1:0][3:0]  len;
        logic                    msb_first;
    } rec_t;

    // 1/2/4/8 byte code 0..3
    function automatic logic [1:0] code1248(input logic [63:0] v);
        logic [1:0] c;
        if (v[63:32] != '0)      c = 2'd3;
        else if (v[31:16] != '0) c = 2'd2;
        else if (v[15:8] != '0)  c = 2'd1;
        else                     c = 2'd0;
        return c;
    endfunction

    // 1/2/4 byte code 1..3
    function automatic logic [1:0] code124(input logic [31:0] v);
        logic [1:0] c;
        if (v[31:16] != '0)     c = 2'd3;
        else if (v[15:8] != '0) c = 2'd2;
        else                    c = 2'd1;
        return c;
    endfunction

    function automatic logic [3:0] len1248(input logic [1:0] c);
        return 4'd1 << c;
    endfunction

    function automatic logic [3:0] len124(input logic [1:0] c);
        logic [3:0] n;
        case (c)
            2'd1:    n = 4'd1;
            2'd2:    n = 4'd2;
            2'd3:    n = 4'd4;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // size minus one (0/1/3) from a 1/2/4 code
    function automatic logic [1:0] minus1_124(input logic [1:0] c);
        logic [1:0] m;
        case (c)
            2'd2:    m = 2'd1;
            2'd3:    m = 2'd3;
            default: m = 2'd0;
        endcase
        return m;
    endfunction

endpackage

[sv/skip_entry_record_packer.sv]
// The first byte of a record passes the front register, the record queue and the output
// register on its way to the output.
// Throughput: one byte per cycle while out_stall is low; a record packs to 2 to 30 bytes,
// and a position record that packs to nothing is dropped by the front and never queued.
// The record queue (QDepth entries) lets the front accept while the emitter is busy.
// Reset: pipeline and queue empty; has_positions=1, has_offsets=0, most_significant_first=1.
// Top level of the skip record packer; depends on sepk_pkg, sepk_front, sepk_queue, sepk_back.
module skip_entry_record_packer #(
    parameter int QDepth = sepk_pkg::QueueDepth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sepk_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [31:0]                   doc_delta_max,
    input  logic [63:0]                   doc_ptr,
    input  logic [63:0]                   pos_ptr,
    input  logic [63:0]                   pay_ptr,
    input  logic [7:0]                    pos_in_block,
    input  logic                          has_score,
    input  logic [31:0]                   score_freq,
    input  logic [31:0]                   score_norm,
    input  logic [15:0]                   block_tail_len,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_byte,
    output logic                          last
);

    sepk_pkg::cfg_t cfg_reg, cfg_next;
    sepk_pkg::rec_t push_rec, head_rec;
    logic           q_full, push, pop, head_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sepk_pkg::RegHasPositions: cfg_next.has_positions = cfg_data;
                sepk_pkg::RegHasOffsets:   cfg_next.has_offsets   = cfg_data;
                sepk_pkg::RegMsbFirst:     cfg_next.msb_first     = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.has_positions <= 1'b1;
            cfg_reg.has_offsets   <= 1'b0;
            cfg_reg.msb_first     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sepk_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .doc_delta_max   (doc_delta_max),
        .doc_ptr         (doc_ptr),
        .pos_ptr         (pos_ptr),
        .pay_ptr         (pay_ptr),
        .pos_in_block    (pos_in_block),
        .has_score       (has_score),
        .score_freq      (score_freq),
        .score_norm      (score_norm),
        .block_tail_len  (block_tail_len),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .push            (push),
        .push_rec        (push_rec)
    );

    sepk_queue #(
        .Depth (QDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    sepk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last       (last)
    );

endmodule

[sv/sepk_queue.sv]
// Record queue between the classify front and the byte emitter.
// Depends on sepk_pkg (rec_t).
module sepk_queue #(
    parameter int Depth = sepk_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sepk_pkg::rec_t  push_rec,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sepk_pkg::rec_t  head_rec
);

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    sepk_pkg::rec_t  mem_reg [Depth];
    logic [IdxW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[sv/sepk_front.sv]
// Front stage: takes input transactions, sizes every value and builds the
// segment list of one record. Depends on sepk_pkg.
module sepk_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      action,
    input  logic [31:0]     doc_delta_max,
    input  logic [63:0]     doc_ptr,
    input  logic [63:0]     pos_ptr,
    input  logic [63:0]     pay_ptr,
    input  logic [7:0]      pos_in_block,
    input  logic            has_score,
    input  logic [31:0]     score_freq,
    input  logic [31:0]     score_norm,
    input  logic [15:0]     block_tail_len,
    input  sepk_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            push,
    output sepk_pkg::rec_t  push_rec
);

    sepk_pkg::rec_t rec_c;
    sepk_pkg::rec_t rec_reg;
    logic           valid_reg, valid_next;
    logic           nonempty_c;
    logic           use_pay;
    logic [1:0]     mdd_c, doc_c, pos_c, pay_c, pos32_c, pay32_c;
    logic [1:0]     freq_c, norm_c, fsel_c, nsel_c;
    logic           load;

    assign in_stall = valid_reg && q_full;
    assign load     = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign push_rec = rec_reg;

    always_comb
    begin
        mdd_c   = sepk_pkg::code124(doc_delta_max);
        doc_c   = sepk_pkg::code1248(doc_ptr);
        pos_c   = sepk_pkg::code1248(pos_ptr);
        pay_c   = sepk_pkg::code1248(pay_ptr);
        pos32_c = sepk_pkg::code124(pos_ptr[31:0]);
        pay32_c = sepk_pkg::code124(pay_ptr[31:0]);
        freq_c  = sepk_pkg::code124(score_freq);
        norm_c  = (score_norm != '0) ? sepk_pkg::code124(score_norm) : 2'd0;
        fsel_c  = has_score ? freq_c : 2'd0;
        nsel_c  = has_score ? norm_c : 2'd0;
        use_pay = cfg.has_positions && cfg.has_offsets;
    end

    always_comb
    begin
        rec_c           = '0;
        rec_c.msb_first = cfg.msb_first;
        nonempty_c      = 1'b1;
        case (sepk_pkg::action_t'(action))
            sepk_pkg::ACT_SKIP:
            begin
                rec_c.val[0] = {56'd0,
                                use_pay ? pay_c : 2'd0,
                                cfg.has_positions ? pos_c : 2'd0,
                                doc_c,
                                sepk_pkg::minus1_124(mdd_c)};
                rec_c.len[0] = 4'd1;
                rec_c.val[1] = {32'd0, doc_delta_max};
                rec_c.len[1] = sepk_pkg::len124(mdd_c);
                rec_c.val[2] = doc_ptr;
                rec_c.len[2] = sepk_pkg::len1248(doc_c);
                if (cfg.has_positions)
                begin
                    rec_c.val[3] = pos_ptr;
                    rec_c.len[3] = sepk_pkg::len1248(pos_c);
                    if (use_pay)
                    begin
                        rec_c.val[4] = pay_ptr;
                        rec_c.len[4] = sepk_pkg::len1248(pay_c);
                    end
                    rec_c.val[5] = {56'd0, pos_in_block};
                    rec_c.len[5] = 4'd1;
                end
            end
            sepk_pkg::ACT_INLINE:
            begin
                rec_c.val[0] = {56'd0, 2'd0, nsel_c, fsel_c, sepk_pkg::minus1_124(mdd_c)};
                rec_c.len[0] = 4'd1;
                rec_c.val[1] = {32'd0, doc_delta_max};
                rec_c.len[1] = sepk_pkg::len124(mdd_c);
                rec_c.val[2] = {32'd0, score_freq};
                rec_c.len[2] = sepk_pkg::len124(fsel_c);
                rec_c.val[3] = {32'd0, score_norm};
                rec_c.len[3] = sepk_pkg::len124(nsel_c);
                rec_c.val[4] = {48'd0, block_tail_len};
                rec_c.len[4] = 4'd2;
            end
            sepk_pkg::ACT_SCORE:
            begin
                rec_c.val[0] = {56'd0, 4'd0, norm_c, freq_c};
                rec_c.len[0] = 4'd1;
                rec_c.val[1] = {32'd0, score_freq};
                rec_c.len[1] = sepk_pkg::len124(freq_c);
                rec_c.val[2] = {32'd0, score_norm};
                rec_c.len[2] = sepk_pkg::len124(norm_c);
            end
            sepk_pkg::ACT_POSMETA:
            begin
                // drop the record when positions are off
                nonempty_c   = cfg.has_positions;
                rec_c.val[0] = {32'd0, pos_ptr[31:0]};
                rec_c.len[0] = sepk_pkg::len124(pos32_c);
                if (cfg.has_offsets)
                begin
                    rec_c.val[1] = {32'd0, pay_ptr[31:0]};
                    rec_c.len[1] = sepk_pkg::len124(pay32_c);
                end
                rec_c.val[2] = {56'd0, pos_in_block};
                rec_c.len[2] = 4'd1;
                rec_c.val[3] = {56'd0, 4'd0,
                                cfg.has_offsets ? sepk_pkg::minus1_124(pay32_c) : 2'd0,
                                sepk_pkg::minus1_124(pos32_c)};
                rec_c.len[3] = 4'd1;
            end
            default:
            begin
                nonempty_c = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = nonempty_c;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_c;
        end
    end

endmodule

[sv/sepk_back.sv]
// Back stage: walks the segments of the queue head and emits one byte per
// transaction through an output register. Depends on sepk_pkg.
module sepk_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  sepk_pkg::rec_t  head_rec,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            last
);

    logic [sepk_pkg::SlotW-1:0] slot_reg, slot_next, nxt_slot;
    logic [2:0]                 byte_reg, byte_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg;
    logic                       last_reg;
    logic                       later_any;
    logic [2:0]                 top_idx, k;
    logic [63:0]                seg_val;
    logic [7:0]                 byte_c;
    logic                       seg_done, rec_last, emit;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // nearest present segment after the current one
    always_comb
    begin
        later_any = 1'b0;
        nxt_slot  = slot_reg;
        for (int s = sepk_pkg::SegCnt - 1; s >= 0; s--)
        begin
            if (sepk_pkg::SlotW'(s) > slot_reg && head_rec.len[s] != 4'd0)
            begin
                later_any = 1'b1;
                nxt_slot  = sepk_pkg::SlotW'(s);
            end
        end
    end

    always_comb
    begin
        top_idx  = 3'(head_rec.len[slot_reg] - 4'd1);
        k        = head_rec.msb_first ? (top_idx - byte_reg) : byte_reg;
        seg_val  = head_rec.val[slot_reg];
        byte_c   = seg_val[{k, 3'b000} +: 8];
        seg_done = (byte_reg == top_idx);
        rec_last = seg_done && !later_any;
        emit     = head_valid && (!out_valid_reg || !out_stall);
        pop      = emit && rec_last;
    end

    always_comb
    begin
        slot_next      = slot_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (rec_last)
            begin
                slot_next = '0;
                byte_next = '0;
            end
            else if (seg_done)
            begin
                slot_next = nxt_slot;
                byte_next = '0;
            end
            else
            begin
                byte_next = byte_reg + 3'd1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            byte_reg      <= byte_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_c;
            last_reg     <= rec_last;
        end
    end

endmodule

[sv/sepk_checker.sv]
// Port-level checker for the skip record packer, bound to the top level.
// Depends on sepk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sepk_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [sepk_pkg::CfgIdxW-1:0]  cfg_index,
    input logic                          cfg_data,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    action,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [7:0]                    out_byte,
    input logic                          last
);

    logic       hp_reg;
    logic [3:0] pending_reg, pending_next;
    logic       in_acc, out_end, rec_nonempty;

    // track records accepted and not yet finished on the output
    assign in_acc       = in_valid && !in_stall;
    assign out_end      = out_valid && !out_stall && last;
    assign rec_nonempty = !(action == sepk_pkg::ACT_POSMETA && !hp_reg);

    always_comb
    begin
        pending_next = pending_reg;
        if ((in_acc && rec_nonempty) && !out_end)
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (!(in_acc && rec_nonempty) && out_end)
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg      <= 1'b1;
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_we && cfg_index == sepk_pkg::RegHasPositions)
            begin
                hp_reg <= cfg_data;
            end
        end
    end

    `SEPK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                      out_valid && $stable(out_byte) && $stable(last))
    `SEPK_ASSERT_IMPL(a_no_stray_byte, clk, rst_n, out_valid, pending_reg != 4'd0)
    `SEPK_ASSERT_IMPL(a_stall_busy, clk, rst_n, in_stall, pending_reg != 4'd0)

endmodule

bind skip_entry_record_packer sepk_checker u_sepk_checker (.*);
